/* rtl/min_heap_priority_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the min-heap priority queue
// Shared property forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define MHPQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Sizes, request and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY = 30;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RAM_DEPTH = CAPACITY + 1;

    localparam int KEY_W  = 16;
    localparam int PAY_W  = 16;
    localparam int ENT_W  = KEY_W + PAY_W;
    localparam int POS_W  = 5;
    localparam int FILL_W = 5;
    localparam int MODE_W = 2;
    localparam int ST_W   = 3;

    localparam int IN_FIELD_W  = KEY_W + PAY_W + POS_W;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = KEY_W + PAY_W + FILL_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXTRACT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTDEC = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INS_INIT,
        OP_RD_PARENT,
        OP_UP_MOVE,
        OP_PLACE,
        OP_RD_ROOT,
        OP_RD_LAST,
        OP_EX_INIT,
        OP_RD_LEFT,
        OP_RD_RIGHT,
        OP_DN_MOVE,
        OP_RD_DEC,
        OP_DEC_INIT,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op          op;
        logic            set_st;
        logic [ST_W-1:0] st;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              pos_bad;
        logic              not_dec;
        logic              up_more;
        logic              up_move;
        logic              dn_more;
        logic              dn_stop;
        logic              out_busy;
    } t_dp_stat;

endpackage

/* rtl/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue controller
// Sequences each request through the datapath, one heap access per step.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_unit_assert.svh"

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_CHK,
        S_DN_RIGHT,
        S_DN_CMP,
        S_DEC_CHK,
        S_UP_CHK,
        S_UP_CMP,
        S_EMIT
    } t_state;

    t_state  r_state, n_state;
    logic    r_in_ready, n_in_ready;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        w_cmd      = '{op: OP_NONE, set_st: 1'b0, st: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.op   = OP_LOAD;
                    n_state    = S_DECODE;
                    n_in_ready = 1'b0;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                priority if (i_stat.mode == MODE_INSERT) begin
                    if (i_stat.full) begin
                        w_cmd.set_st = 1'b1;
                        w_cmd.st     = ST_FULL;
                    end else begin
                        w_cmd.op = OP_INS_INIT;
                        n_state  = S_UP_CHK;
                    end
                end else if (i_stat.mode == MODE_EXTRACT) begin
                    if (i_stat.empty) begin
                        w_cmd.set_st = 1'b1;
                        w_cmd.st     = ST_EMPTY;
                    end else begin
                        w_cmd.op = OP_RD_ROOT;
                        n_state  = S_EX_ROOT;
                    end
                end else if (i_stat.mode == MODE_DECREASE) begin
                    priority if (i_stat.empty) begin
                        w_cmd.set_st = 1'b1;
                        w_cmd.st     = ST_EMPTY;
                    end else if (i_stat.pos_bad) begin
                        w_cmd.set_st = 1'b1;
                        w_cmd.st     = ST_BADPOS;
                    end else begin
                        w_cmd.op = OP_RD_DEC;
                        n_state  = S_DEC_CHK;
                    end
                end else begin
                    // unused request code: report with no change
                    n_state = S_EMIT;
                end
            end
            S_EX_ROOT: begin
                w_cmd.op = OP_RD_LAST;
                n_state  = S_EX_LAST;
            end
            S_EX_LAST: begin
                w_cmd.op = OP_EX_INIT;
                n_state  = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_stat.dn_more) begin
                    w_cmd.op = OP_RD_LEFT;
                    n_state  = S_DN_RIGHT;
                end else begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_EMIT;
                end
            end
            S_DN_RIGHT: begin
                w_cmd.op = OP_RD_RIGHT;
                n_state  = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_stop) begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_EMIT;
                end else begin
                    w_cmd.op = OP_DN_MOVE;
                    n_state  = S_DN_CHK;
                end
            end
            S_DEC_CHK: begin
                if (i_stat.not_dec) begin
                    w_cmd.set_st = 1'b1;
                    w_cmd.st     = ST_NOTDEC;
                    n_state      = S_EMIT;
                end else begin
                    w_cmd.op = OP_DEC_INIT;
                    n_state  = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_stat.up_more) begin
                    w_cmd.op = OP_RD_PARENT;
                    n_state  = S_UP_CMP;
                end else begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_EMIT;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_move) begin
                    w_cmd.op = OP_UP_MOVE;
                    n_state  = S_UP_CHK;
                end else begin
                    w_cmd.op = OP_PLACE;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    w_cmd.op   = OP_EMIT;
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = w_cmd;

    `MHPQ_ASSERT_IMPL(a_ready_only_idle, r_in_ready, r_state == S_IDLE, "ready outside idle")
    `MHPQ_ASSERT_NEXT(a_accept_decodes, r_in_ready && i_in_valid, r_state == S_DECODE && !r_in_ready, "accepted beat not decoded")

endmodule

/* rtl/mhpq_datapath.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue datapath
// Heap RAM, fill count, moving entry, comparators and the result register.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_unit_assert.svh"

module mhpq_datapath
    import mhpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [MODE_W-1:0] i_in_mode,
    input  logic [KEY_W-1:0]  i_in_key,
    input  logic [PAY_W-1:0]  i_in_payload,
    input  logic [POS_W-1:0]  i_in_position,
    input  logic              i_out_ready,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [PAY_W-1:0]  o_out_payload,
    output logic [ST_W-1:0]   o_out_status,
    output logic [FILL_W-1:0] o_out_fill
);

    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [PAY_W-1:0]  r_pay;
    logic [POS_W-1:0]  r_position;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_pos;
    logic [ENT_W-1:0]  r_ent;
    logic [ENT_W-1:0]  r_left;
    logic [KEY_W-1:0]  r_okey;
    logic [PAY_W-1:0]  r_opay;
    logic [ST_W-1:0]   r_status;
    logic              r_out_valid;
    logic [KEY_W-1:0]  r_out_key;
    logic [PAY_W-1:0]  r_out_pay;
    logic [ST_W-1:0]   r_out_st;
    logic [FILL_W-1:0] r_out_fill;

    logic              ram_wr_en;
    logic [CNT_W-1:0]  ram_wr_addr;
    logic [ENT_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [CNT_W-1:0]  ram_rd_addr;
    logic [ENT_W-1:0]  ram_rd_data;

    logic [CNT_W:0]    w_child;
    logic [CNT_W:0]    w_child_r;
    logic [CNT_W:0]    w_count_x;
    logic              w_has_right;
    logic [KEY_W-1:0]  w_rd_key;
    logic [KEY_W-1:0]  w_ent_key;
    logic [KEY_W-1:0]  w_left_key;
    logic              w_pick_right;
    logic [ENT_W-1:0]  w_child_ent;
    logic [CNT_W:0]    w_child_idx;
    logic [CNT_W-1:0]  w_pos_in;

    mhpq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign w_child      = {r_pos, 1'b0};
    assign w_child_r    = w_child + (CNT_W + 1)'(1);
    assign w_count_x    = {1'b0, r_count};
    assign w_has_right  = w_child < w_count_x;
    assign w_rd_key     = ram_rd_data[ENT_W-1 -: KEY_W];
    assign w_ent_key    = r_ent[ENT_W-1 -: KEY_W];
    assign w_left_key   = r_left[ENT_W-1 -: KEY_W];
    // right child wins only when the left key is strictly larger
    assign w_pick_right = w_has_right && (w_left_key > w_rd_key);
    assign w_child_ent  = w_pick_right ? ram_rd_data : r_left;
    assign w_child_idx  = w_pick_right ? w_child_r : w_child;
    assign w_pos_in     = CNT_W'(r_position);

    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.full     = r_count == CNT_W'(CAPACITY);
        o_stat.empty    = r_count == '0;
        o_stat.pos_bad  = (r_position == '0)
                       || ({{CNT_W{1'b0}}, r_position} > {{POS_W{1'b0}}, r_count});
        o_stat.not_dec  = r_key > w_rd_key;
        o_stat.up_more  = r_pos > CNT_W'(1);
        // decrease climbs past equal parents, insert only past larger ones
        o_stat.up_move  = (r_mode == MODE_DECREASE) ? (w_ent_key <= w_rd_key)
                                                    : (w_ent_key < w_rd_key);
        o_stat.dn_more  = w_child <= w_count_x;
        o_stat.dn_stop  = w_ent_key <= w_child_ent[ENT_W-1 -: KEY_W];
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_pos;
        ram_wr_data = r_ent;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_pos;
        unique case (i_cmd.op)
            OP_RD_PARENT: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_pos >> 1;
            end
            OP_RD_ROOT: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = CNT_W'(1);
            end
            OP_RD_LAST: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_count;
            end
            OP_RD_LEFT: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = w_child[CNT_W-1:0];
            end
            OP_RD_RIGHT: begin
                ram_rd_en   = w_has_right;
                ram_rd_addr = w_child_r[CNT_W-1:0];
            end
            OP_RD_DEC: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = w_pos_in;
            end
            OP_UP_MOVE: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
            end
            OP_PLACE: begin
                ram_wr_en   = 1'b1;
            end
            OP_DN_MOVE: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = w_child_ent;
            end
            default: begin
                ram_wr_en = 1'b0;
                ram_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_INS_INIT) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.op == OP_EX_INIT) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_mode     <= i_in_mode;
                r_key      <= i_in_key;
                r_pay      <= i_in_payload;
                r_position <= i_in_position;
                r_okey     <= '0;
                r_opay     <= '0;
            end
            OP_INS_INIT: begin
                r_pos <= r_count + CNT_W'(1);
                r_ent <= {r_key, r_pay};
            end
            OP_UP_MOVE: begin
                r_pos <= r_pos >> 1;
            end
            OP_RD_LAST: begin
                r_okey <= w_rd_key;
                r_opay <= ram_rd_data[PAY_W-1:0];
            end
            OP_EX_INIT: begin
                r_ent <= ram_rd_data;
                r_pos <= CNT_W'(1);
            end
            OP_RD_RIGHT: begin
                r_left <= ram_rd_data;
            end
            OP_DN_MOVE: begin
                r_pos <= w_child_idx[CNT_W-1:0];
            end
            OP_RD_DEC: begin
                r_pos <= w_pos_in;
            end
            OP_DEC_INIT: begin
                r_ent <= {r_key, ram_rd_data[PAY_W-1:0]};
            end
            OP_EMIT: begin
                r_out_key  <= r_okey;
                r_out_pay  <= r_opay;
                r_out_st   <= r_status;
                r_out_fill <= FILL_W'(r_count);
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
        if (i_cmd.op == OP_LOAD) begin
            r_status <= ST_OK;
        end else if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_pay;
    assign o_out_status  = r_out_st;
    assign o_out_fill    = r_out_fill;

    `MHPQ_ASSERT_IMPL(a_count_in_range, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count above capacity")
    `MHPQ_ASSERT_IMPL(a_write_in_heap, ram_wr_en, ram_wr_addr != '0 && ram_wr_addr <= CNT_W'(CAPACITY), "heap write outside positions")
    `MHPQ_ASSERT_IMPL(a_emit_when_free, i_cmd.op == OP_EMIT, !(r_out_valid && !i_out_ready), "result overwritten while stalled")

endmodule

/* rtl/min_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue unit
// Binary min-heap of key/payload entries with insert, extract and decrease.
// ----------------------------------------------------------------------------
// The queue takes one request at a time and answers each with exactly one
// result beat carrying a status and the fill count. The heap lives in a RAM
// with one read and one write port and registered read data, so every level
// of a sift first reads the parent, or the children, and then moves the entry.
// A decrease reads its entry before it climbs, and an extract reads the root
// and the last entry before it sinks. An entry moves at most 4 levels in a
// heap of 30 entries. A request refused as full, empty or at a bad position,
// and one in the unused mode, is answered without a heap access; a decrease
// refused for a larger key reads its entry first. A result held by a stalled
// consumer only delays the following request once that one is ready to
// report. No clearing pass is needed after reset.
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key, payload, position
    input  logic [MODE_W-1:0]     s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_key, out_payload, fill_count
    output logic [ST_W-1:0]       m_axis_tuser   // status
);

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [KEY_W-1:0]  w_out_key;
    logic [PAY_W-1:0]  w_out_pay;
    logic [FILL_W-1:0] w_out_fill;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mhpq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_mode     (s_axis_tuser),
        .i_in_key      (s_axis_tdata[KEY_W-1:0]),
        .i_in_payload  (s_axis_tdata[KEY_W +: PAY_W]),
        .i_in_position (s_axis_tdata[KEY_W+PAY_W +: POS_W]),
        .i_out_ready   (m_axis_tready),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_out_key     (w_out_key),
        .o_out_payload (w_out_pay),
        .o_out_status  (m_axis_tuser),
        .o_out_fill    (w_out_fill)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_out_fill, w_out_pay, w_out_key};

endmodule

/* bench/tb_min_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Min-heap priority queue unit testbench
// Drives insert, extract-min and decrease-key requests over the input stream.
// Each accepted request runs through a behavioural heap in the bench, and each
// result beat is compared field by field, in order, with what that heap gives.
// Covers empty and full heaps, bad positions, refused decreases, key ties and
// the unused mode. Both stream sides idle at random, with one long consumer
// hold-off and some drain pauses on the producer side.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_unit;
    import mhpq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 50;

    typedef struct packed {
        logic              drain_first;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  pay;
        logic [POS_W-1:0]  pos;
    } t_heap_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  pay;
        logic [ST_W-1:0]   st;
        logic [FILL_W-1:0] fill;
    } t_heap_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key, payload, position
    logic [MODE_W-1:0]     s_axis_tuser = '0;   // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // out_key, out_payload, fill_count
    logic [ST_W-1:0]       m_axis_tuser;        // status

    min_heap_priority_queue_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bench copy of the heap, 1-based, key in the upper half
    logic [ENT_W-1:0] heap_ent [1:CAPACITY];
    int               heap_fill = 0;

    t_heap_req req_queue [$];
    t_heap_res exp_results [$];
    int        gen_fill = 0;
    int        n_total = 0;
    int        n_acc = 0;
    int        n_done = 0;
    int        n_mismatch = 0;

    task automatic sift_up(input int start, input logic [ENT_W-1:0] ent, input bit climb_eq);
        int  p;
        bit  moving;
        logic [KEY_W-1:0] pk;
        p = start;
        moving = 1'b1;
        while (moving && p > 1) begin
            pk = heap_ent[p / 2][ENT_W-1:PAY_W];
            if (climb_eq ? (ent[ENT_W-1:PAY_W] <= pk) : (ent[ENT_W-1:PAY_W] < pk)) begin
                heap_ent[p] = heap_ent[p / 2];
                p = p / 2;
            end else begin
                moving = 1'b0;
            end
        end
        heap_ent[p] = ent;
    endtask

    task automatic apply_request(input t_heap_req r, output t_heap_res res);
        logic [ENT_W-1:0] root;
        logic [ENT_W-1:0] last;
        int  parent;
        int  child;
        bit  settled;
        res = '0;
        res.st = ST_OK;
        case (r.mode)
            MODE_INSERT: begin
                if (heap_fill >= CAPACITY) begin
                    res.st = ST_FULL;
                end else begin
                    heap_fill++;
                    sift_up(heap_fill, {r.key, r.pay}, 1'b0);
                end
            end
            MODE_EXTRACT: begin
                if (heap_fill == 0) begin
                    res.st = ST_EMPTY;
                end else begin
                    root = heap_ent[1];
                    last = heap_ent[heap_fill];
                    res.key = root[ENT_W-1:PAY_W];
                    res.pay = root[PAY_W-1:0];
                    heap_fill--;
                    // sift the last entry down from the root, smaller child first
                    parent = 1;
                    child = 2;
                    settled = 1'b0;
                    while (!settled && child <= heap_fill) begin
                        if (child < heap_fill && heap_ent[child][ENT_W-1:PAY_W] >
                                heap_ent[child + 1][ENT_W-1:PAY_W])
                            child++;
                        if (last[ENT_W-1:PAY_W] <= heap_ent[child][ENT_W-1:PAY_W]) begin
                            settled = 1'b1;
                        end else begin
                            heap_ent[parent] = heap_ent[child];
                            parent = child;
                            child = child * 2;
                        end
                    end
                    heap_ent[parent] = last;
                end
            end
            MODE_DECREASE: begin
                if (heap_fill == 0)
                    res.st = ST_EMPTY;
                else if (r.pos == 0 || r.pos > heap_fill)
                    res.st = ST_BADPOS;
                else if (r.key > heap_ent[r.pos][ENT_W-1:PAY_W])
                    res.st = ST_NOTDEC;
                else
                    sift_up(r.pos, {r.key, heap_ent[r.pos][PAY_W-1:0]}, 1'b1);
            end
            default: ;
        endcase
        res.fill = heap_fill[FILL_W-1:0];
    endtask

    // queue one request and track the fill it leaves, so positions stay in range
    task automatic add_req(input logic [MODE_W-1:0] mode, input int key, input int pay,
                           input int pos, input bit drain_first);
        t_heap_req r;
        r.drain_first = drain_first;
        r.mode = mode;
        r.key = key[KEY_W-1:0];
        r.pay = pay[PAY_W-1:0];
        r.pos = pos[POS_W-1:0];
        req_queue.push_back(r);
        if (mode == MODE_INSERT && gen_fill < CAPACITY)
            gen_fill++;
        else if (mode == MODE_EXTRACT && gen_fill > 0)
            gen_fill--;
    endtask

    function automatic int pick_key();
        // small keys often, to force ties
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 31);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int pick_pos();
        if (gen_fill == 0)
            return $urandom_range(1, 31);
        return $urandom_range(1, gen_fill);
    endfunction

    // producer
    always @(posedge i_clk) begin : drive_requests
        t_heap_req nxt;
        t_heap_res res;
        bit        accept;
        int        outstanding;
        static t_heap_req cur_req = '0;
        static int idle_left = 0;
        static int idle_pct = 10;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            accept = s_axis_tvalid && s_axis_tready;
            if (accept) begin
                apply_request(cur_req, res);
                exp_results.push_back(res);
                n_acc <= n_acc + 1;
                if ((n_acc + 1) % 64 == 0) begin
                    case ($urandom_range(0, 3))
                        0: idle_pct = 0;
                        1: idle_pct = 5;
                        2: idle_pct = 25;
                        default: idle_pct = 60;
                    endcase
                end
            end
            outstanding = n_acc + accept - n_done - (m_axis_tvalid && m_axis_tready);
            if (!s_axis_tvalid || accept) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (req_queue[0].drain_first && outstanding != 0) begin
                    // hold until every result is back
                    s_axis_tvalid <= 1'b0;
                end else begin
                    nxt = req_queue.pop_front();
                    cur_req = nxt;
                    s_axis_tdata <= {{(IN_DATA_W - IN_FIELD_W){1'b0}}, nxt.pos, nxt.pay, nxt.key};
                    s_axis_tuser <= nxt.mode;
                    s_axis_tvalid <= 1'b1;
                    if (req_queue.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct)
                        idle_left = $urandom_range(1, 17);
                end
            end
        end
    end

    // consumer and checker
    always @(posedge i_clk) begin : check_results
        t_heap_res want;
        t_heap_res got;
        static int  stall_left = 0;
        static int  stall_pct = 20;
        static bit  long_done = 1'b0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_done <= n_done + 1;
                got.key = m_axis_tdata[KEY_W-1:0];
                got.pay = m_axis_tdata[KEY_W+PAY_W-1:KEY_W];
                got.fill = m_axis_tdata[OUT_FIELD_W-1:KEY_W+PAY_W];
                got.st = m_axis_tuser;
                if (exp_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result beat: key %h payload %h status %0d fill %0d",
                                 got.key, got.pay, got.st, got.fill);
                end else begin
                    want = exp_results.pop_front();
                    if (got !== want) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"result %0d mismatch: expected key %h payload %h status %0d",
                                      " fill %0d, got key %h payload %h status %0d fill %0d"},
                                     n_done, want.key, want.pay, want.st, want.fill,
                                     got.key, got.pay, got.st, got.fill);
                    end
                end
                if ((n_done + 1) % 80 == 0)
                    stall_pct = $urandom_range(0, 2) * 25;
            end
            // one long hold-off to back the queue up into the input side
            if (!long_done && n_done >= 300) begin
                long_done = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && n_done + TAIL_ITEMS < n_total &&
                         $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : run_sequence
        int n_rand;
        int len;
        int sel;
        int since_drain;
        // empty heap, unused mode
        add_req(MODE_EXTRACT, 0, 0, 0, 1'b0);
        add_req(MODE_DECREASE, 0, 0, 1, 1'b0);
        add_req(MODE_UNUSED, 0, 0, 0, 1'b0);
        // key and payload extremes, a tie with the root
        add_req(MODE_INSERT, 16'hFFFF, 16'h0000, 0, 1'b0);
        add_req(MODE_INSERT, 16'h0000, 16'hFFFF, 31, 1'b0);
        add_req(MODE_INSERT, 16'h8000, 16'h1234, 0, 1'b0);
        add_req(MODE_INSERT, 16'h0000, 16'hAAAA, 0, 1'b0);
        add_req(MODE_INSERT, 16'h0005, 16'h5555, 0, 1'b0);
        // bad positions: zero, all ones, just past the fill
        add_req(MODE_DECREASE, 16'h0000, 0, 0, 1'b0);
        add_req(MODE_DECREASE, 16'hFFFF, 16'hFFFF, 31, 1'b0);
        add_req(MODE_DECREASE, 16'h0000, 0, 6, 1'b0);
        // larger key refused, equal key accepted, climb past equal parents
        add_req(MODE_DECREASE, 16'hFFFF, 0, 1, 1'b0);
        add_req(MODE_DECREASE, 16'h0005, 0, 5, 1'b0);
        add_req(MODE_DECREASE, 16'h0000, 0, 4, 1'b0);
        add_req(MODE_DECREASE, 16'h7FFF, 0, 3, 1'b0);
        add_req(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 31, 1'b0);
        repeat (6) add_req(MODE_EXTRACT, 0, 0, 0, 1'b0);

        n_rand = 0;
        since_drain = 0;
        while (n_rand < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            len = $urandom_range(5, 40);
            repeat (len) begin
                since_drain++;
                if (sel < 3) begin
                    // fill run, long enough to hit a full heap
                    if ($urandom_range(0, 9) < 8)
                        add_req(MODE_INSERT, pick_key(), $urandom_range(0, 65535),
                                $urandom_range(0, 31), since_drain > 120);
                    else
                        add_req(MODE_DECREASE, pick_key(), $urandom_range(0, 65535),
                                pick_pos(), since_drain > 120);
                end else if (sel < 5) begin
                    add_req(MODE_EXTRACT, $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 31), since_drain > 120);
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8:
                            add_req(MODE_INSERT, pick_key(), $urandom_range(0, 65535),
                                    $urandom_range(0, 31), since_drain > 120);
                        9, 10, 11, 12, 13, 14:
                            add_req(MODE_EXTRACT, 0, $urandom_range(0, 65535), 0,
                                    since_drain > 120);
                        15, 16, 17:
                            add_req(MODE_DECREASE,
                                    ($urandom_range(0, 3) == 0) ? 0 : pick_key(),
                                    $urandom_range(0, 65535), pick_pos(), since_drain > 120);
                        18:
                            add_req(MODE_DECREASE, pick_key(), $urandom_range(0, 65535),
                                    ($urandom_range(0, 1) == 0) ? 0
                                        : $urandom_range((gen_fill < 31) ? gen_fill + 1 : 31, 31),
                                    since_drain > 120);
                        default:
                            add_req(MODE_UNUSED, $urandom_range(0, 65535),
                                    $urandom_range(0, 65535), $urandom_range(0, 31),
                                    since_drain > 120);
                    endcase
                end
                if (since_drain > 120)
                    since_drain = 0;
                n_rand++;
            end
        end
        n_total = req_queue.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_queue.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (n_done != n_acc)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_mismatch == 0 && exp_results.size() == 0 && n_done == n_acc) begin
            $display("min_heap_priority_queue_unit verification clean");
        end else begin
            $display("min_heap_priority_queue_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(12 * 400000);
        $display("min_heap_priority_queue_unit verification failed");
        $finish;
    end

endmodule
